// ----- rtl/core/well512_pkg.sv -----
package well512_pkg;

  // pool geometry and beat widths
  localparam int unsigned POOL_DEPTH  = 16;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 104;

  // seeding and tempering constants
  localparam logic [31:0] DEFAULT_SEED = 32'h5ee3_9c34;
  localparam logic [31:0] SEED_XOR     = 32'hf68a_9fc1;
  localparam logic [31:0] SEED_MUL     = 32'h6c07_8965;
  localparam logic [31:0] TEMPER_MASK  = 32'hda44_2d20;

  // last pool slot written by the seeding chain
  localparam logic [SLOT_W-1:0] SEED_LAST = SLOT_W'(POOL_DEPTH - 1);

  // operation codes carried on tuser
  typedef enum logic [OP_W-1:0] {
    OP_NEXT   = 3'd0,
    OP_RESEED = 3'd1,
    OP_WRITE  = 3'd2,
    OP_SETPOS = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_RD_A,
    DP_RD_B,
    DP_MIX,
    DP_WR_NEW,
    DP_SCALE,
    DP_SEED_FIRST,
    DP_SEED_STEP,
    DP_WR_SLOT,
    DP_SET_POS,
    DP_RD_SLOT
  } dp_op_t;

  // command bundle from controller to datapath
  typedef struct packed {
    dp_op_t             op;
    logic               use_default;
    logic [SLOT_W-1:0]  step;
    logic               load_out;
  } dp_cmd_t;

  // controller states
  typedef enum logic [3:0] {
    ST_BOOT_FIRST,
    ST_BOOT_STEP,
    ST_IDLE,
    ST_SEED_FIRST,
    ST_SEED_STEP,
    ST_NX_RD_A,
    ST_NX_RD_B,
    ST_NX_MIX,
    ST_NX_WR,
    ST_NX_SCALE,
    ST_WRITE,
    ST_SETPOS,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/well512_random_generator.sv -----
// WELL512a random generator with exact ranged scaling.
// Input beats carry the operation on s_tuser (0 next number, 1 reseed,
// 2 write pool word, 3 set position, 4 read pool word) and the operands on
// s_tdata. Every input beat gives exactly one result beat on m_tdata with
// the raw number, the ranged number, the read word and the position.
// Items are handled one at a time by a controller sequencing a datapath
// around a 16-word pool memory with one write and two read ports.
// Steps per item, from accept to result beat: next number makes two pool
// reads, then mix, write-back, 32x33 multiply and scale; write, set and read
// one datapath step each; reseed seeds word 0, then one multiply per further
// pool word; unused codes go straight to the result. Pool ports set the steps.
// After reset the block seeds the whole pool from the default seed with
// s_tready low; the position resets to zero.
// A finished result sits in the output register; while the receiver stalls
// the next beat may still be accepted, but its result waits until the
// output register is taken.
module well512_random_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[2:0]
  input  logic [2:0]   s_tuser,
  // word_value[31:0], word_slot[35:32], range_low[67:36], range_high[99:68]
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // raw_number[31:0], ranged_number[63:32], read_word[95:64],
  // read_position[99:96]
  output logic [103:0] m_tdata
);
  import well512_pkg::*;

  dp_cmd_t cmd;

  // sequencer
  well512_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  // pool, mixing and scaling
  well512_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .out_data (m_tdata)
  );

  // an accepted beat closes the input until its result is formed
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input stayed open after accept");

  // no datapath work other than capture while waiting for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (cmd.op == DP_NOP || cmd.op == DP_CAPTURE))
    else $error("datapath busy while idle");

  // a result is only loaded when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result overwritten before taken");

  // the seeding pass after reset holds off input
  a_boot_closed: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input open during seeding pass");

endmodule

// ----- rtl/core/well512_dp.sv -----
module well512_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  well512_pkg::dp_cmd_t                  cmd,
  input  logic [well512_pkg::IN_TDATA_W-1:0]    in_data,
  input  logic [well512_pkg::OP_W-1:0]          in_user,
  output logic [well512_pkg::OUT_TDATA_W-1:0]   out_data
);
  import well512_pkg::*;

  // pool memory, one write port and two registered read ports
  logic [31:0]       mem [POOL_DEPTH];
  logic [31:0]       rd0;
  logic [31:0]       rd1;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [31:0]       wdata;
  logic              rd_en;
  logic [SLOT_W-1:0] raddr0;
  logic [SLOT_W-1:0] raddr1;

  // captured beat
  op_t               op_q;
  logic [31:0]       val_q;
  logic [SLOT_W-1:0] slot_q;
  logic [31:0]       lo_q;
  logic [32:0]       span_q;
  logic              span_ok_q;

  // generator state and intermediates
  logic [SLOT_W-1:0] pos;
  logic [31:0]       b_q;
  logic [31:0]       raw_q;
  logic [63:0]       prod_q;
  logic [31:0]       ranged_q;
  logic [31:0]       seed_prev;

  // output payload registers
  logic [31:0]       out_raw;
  logic [31:0]       out_ranged;
  logic [31:0]       out_word;
  logic [SLOT_W-1:0] out_pos;

  // combinational helpers
  logic [31:0] lo_in;
  logic [31:0] hi_in;
  logic [33:0] span_in;
  logic [31:0] seed_word;
  logic [31:0] seed_mix;
  logic [31:0] step_word;
  logic [31:0] b_new;
  logic [31:0] c_mix;
  logic [31:0] a_mix;
  logic [31:0] d_mix;
  logic [31:0] new_word;

  // span at 34 bits signed, positive when high >= low
  assign lo_in   = in_data[67:36];
  assign hi_in   = in_data[99:68];
  assign span_in = {{2{hi_in[31]}}, hi_in} - {{2{lo_in[31]}}, lo_in} + 34'd1;

  // seeding chain terms
  assign seed_word = (cmd.use_default ? DEFAULT_SEED : val_q) ^ SEED_XOR;
  assign seed_mix  = seed_prev ^ (seed_prev >> 30);
  assign step_word = 32'(SEED_MUL * seed_mix) + {28'd0, cmd.step};

  // well512 mixing terms
  assign b_new    = rd0 ^ rd1 ^ (rd0 << 16) ^ (rd1 << 15);
  assign c_mix    = rd0 ^ (rd0 >> 11);
  assign a_mix    = b_q ^ c_mix;
  assign d_mix    = a_mix ^ ((a_mix << 5) & TEMPER_MASK);
  assign new_word = rd1 ^ b_q ^ d_mix ^ (rd1 << 2) ^ (b_q << 18) ^ (c_mix << 28);

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = val_q;
    unique case (cmd.op)
      DP_SEED_FIRST: begin
        we    = 1'b1;
        waddr = '0;
        wdata = seed_word;
      end
      DP_SEED_STEP: begin
        we    = 1'b1;
        waddr = cmd.step;
        wdata = step_word;
      end
      DP_MIX: begin
        we    = 1'b1;
        waddr = pos;
        wdata = a_mix;
      end
      DP_WR_NEW: begin
        we    = 1'b1;
        waddr = pos;
        wdata = raw_q;
      end
      DP_WR_SLOT: begin
        we    = 1'b1;
        waddr = slot_q;
        wdata = val_q;
      end
      default: ;
    endcase
  end

  // read port select
  always_comb begin
    rd_en  = 1'b0;
    raddr0 = pos;
    raddr1 = pos;
    unique case (cmd.op)
      DP_RD_A: begin
        rd_en  = 1'b1;
        raddr0 = pos;
        raddr1 = pos + SLOT_W'(13);
      end
      DP_RD_B: begin
        rd_en  = 1'b1;
        raddr0 = pos + SLOT_W'(9);
        raddr1 = pos + SLOT_W'(15);
      end
      DP_RD_SLOT: begin
        rd_en  = 1'b1;
        raddr0 = slot_q;
        raddr1 = slot_q;
      end
      default: ;
    endcase
  end

  // pool memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd0 <= mem[raddr0];
      rd1 <= mem[raddr1];
    end
  end

  // position register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.op == DP_SET_POS) begin
      pos <= slot_q;
    end else if (cmd.op == DP_MIX) begin
      pos <= pos - SLOT_W'(1);
    end
  end

  // beat capture and arithmetic pipeline
  always_ff @(posedge clk) begin
    if (cmd.op == DP_CAPTURE) begin
      op_q      <= op_t'(in_user);
      val_q     <= in_data[31:0];
      slot_q    <= in_data[35:32];
      lo_q      <= lo_in;
      span_q    <= span_in[32:0];
      span_ok_q <= !span_in[33] && (span_in != 34'd0);
    end
    if (cmd.op == DP_SEED_FIRST) begin
      seed_prev <= seed_word;
    end
    if (cmd.op == DP_SEED_STEP) begin
      seed_prev <= step_word;
    end
    if (cmd.op == DP_RD_B) begin
      b_q <= b_new;
    end
    if (cmd.op == DP_MIX) begin
      raw_q <= new_word;
    end
    if (cmd.op == DP_WR_NEW) begin
      prod_q <= {32'd0, raw_q} * {31'd0, span_q};
    end
    if (cmd.op == DP_SCALE) begin
      ranged_q <= span_ok_q ? (lo_q + prod_q[63:32]) : lo_q;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_raw    <= (op_q == OP_NEXT) ? raw_q : 32'd0;
      out_ranged <= (op_q == OP_NEXT) ? ranged_q : 32'd0;
      out_word   <= (op_q == OP_READ) ? rd0 : 32'd0;
      out_pos    <= pos;
    end
  end

  assign out_data = {4'd0, out_pos, out_word, out_ranged, out_raw};

endmodule

// ----- rtl/core/well512_ctrl.sv -----
module well512_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic [well512_pkg::OP_W-1:0]   opcode,
  output logic                           s_tready,
  input  logic                           m_tready,
  output logic                           m_tvalid,
  output well512_pkg::dp_cmd_t           cmd
);
  import well512_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [SLOT_W-1:0] cnt;
  logic [SLOT_W-1:0] cnt_next;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BOOT_FIRST;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cmd.op          = DP_NOP;
    cmd.use_default = 1'b0;
    cmd.step        = cnt;
    cmd.load_out    = 1'b0;
    unique case (state)
      ST_BOOT_FIRST: begin
        cmd.op          = DP_SEED_FIRST;
        cmd.use_default = 1'b1;
        cnt_next        = SLOT_W'(1);
        state_next      = ST_BOOT_STEP;
      end
      ST_BOOT_STEP: begin
        cmd.op   = DP_SEED_STEP;
        cnt_next = cnt + SLOT_W'(1);
        if (cnt == SEED_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op = DP_CAPTURE;
          unique case (op_t'(opcode))
            OP_NEXT:   state_next = ST_NX_RD_A;
            OP_RESEED: state_next = ST_SEED_FIRST;
            OP_WRITE:  state_next = ST_WRITE;
            OP_SETPOS: state_next = ST_SETPOS;
            OP_READ:   state_next = ST_READ;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_SEED_FIRST: begin
        cmd.op     = DP_SEED_FIRST;
        cnt_next   = SLOT_W'(1);
        state_next = ST_SEED_STEP;
      end
      ST_SEED_STEP: begin
        cmd.op   = DP_SEED_STEP;
        cnt_next = cnt + SLOT_W'(1);
        if (cnt == SEED_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_NX_RD_A: begin
        cmd.op     = DP_RD_A;
        state_next = ST_NX_RD_B;
      end
      ST_NX_RD_B: begin
        cmd.op     = DP_RD_B;
        state_next = ST_NX_MIX;
      end
      ST_NX_MIX: begin
        cmd.op     = DP_MIX;
        state_next = ST_NX_WR;
      end
      ST_NX_WR: begin
        cmd.op     = DP_WR_NEW;
        state_next = ST_NX_SCALE;
      end
      ST_NX_SCALE: begin
        cmd.op     = DP_SCALE;
        state_next = ST_DONE;
      end
      ST_WRITE: begin
        cmd.op     = DP_WR_SLOT;
        state_next = ST_DONE;
      end
      ST_SETPOS: begin
        cmd.op     = DP_SET_POS;
        state_next = ST_DONE;
      end
      ST_READ: begin
        cmd.op     = DP_RD_SLOT;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  // result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import well512_pkg::*;

  // spare operation codes, no state change expected
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  localparam logic [31:0] INT_MIN_W = 32'h8000_0000;
  localparam logic [31:0] INT_MAX_W = 32'h7fff_ffff;

  localparam int RANDOM_ITEMS  = 1400;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 30;
  localparam int LONG_STALL    = 250;
  localparam int STALL_AT_BEAT = 400;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [31:0]       value;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       lo;
    logic [31:0]       hi;
    bit                drain;
  } gen_req_t;

  typedef struct {
    logic [31:0]       raw;
    logic [31:0]       ranged;
    logic [31:0]       word;
    logic [SLOT_W-1:0] pos;
  } gen_out_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [2:0]   s_tuser = '0;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;

  well512_random_generator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // generator mirror state
  logic [31:0]       pool_m [POOL_DEPTH];
  logic [SLOT_W-1:0] pos_m;

  gen_req_t pending_reqs[$];
  gen_out_t expected_outs[$];

  int in_count     = 0;
  int total_reqs   = 0;
  int checked      = 0;
  int mismatches   = 0;
  int empty_ranges = 0;
  int op_seen [8];

  // seeding chain over the whole pool
  function automatic void seed_pool(logic [31:0] seed);
    logic [31:0] prev;
    pool_m[0] = seed ^ SEED_XOR;
    for (int k = 1; k < POOL_DEPTH; k++) begin
      prev      = pool_m[k-1];
      pool_m[k] = SEED_MUL * (prev ^ (prev >> 30)) + 32'(k);
    end
  endfunction

  // one well512a step, moves the position back by one
  function automatic logic [31:0] well_advance();
    logic [31:0]       a, b, c, d;
    logic [SLOT_W-1:0] p, p13, p9;
    p   = pos_m;
    p13 = p + 4'd13;
    p9  = p + 4'd9;
    a = pool_m[p];
    c = pool_m[p13];
    b = a ^ c ^ (a << 16) ^ (c << 15);
    c = pool_m[p9];
    c = c ^ (c >> 11);
    a = b ^ c;
    pool_m[p] = a;
    d = a ^ ((a << 5) & TEMPER_MASK);
    p = p + 4'd15;
    pos_m = p;
    a = pool_m[p];
    pool_m[p] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
    return pool_m[p];
  endfunction

  // work out the result beat of one accepted request
  function automatic gen_out_t gen_predict(gen_req_t rq);
    gen_out_t    r;
    longint      span;
    logic [63:0] span_u, prod;
    r = '{default: '0};
    op_seen[rq.op]++;
    case (rq.op)
      OP_NEXT: begin
        span  = longint'($signed(rq.hi)) - longint'($signed(rq.lo)) + 1;
        r.raw = well_advance();
        if (span <= 0) begin
          r.ranged = rq.lo;
          empty_ranges++;
        end else begin
          span_u   = span;
          prod     = {32'b0, r.raw} * span_u;
          r.ranged = rq.lo + prod[63:32];
        end
      end
      OP_RESEED: seed_pool(rq.value);
      OP_WRITE:  pool_m[rq.slot] = rq.value;
      OP_SETPOS: pos_m = rq.slot;
      OP_READ:   r.word = pool_m[rq.slot];
      default: ;
    endcase
    r.pos = pos_m;
    return r;
  endfunction

  // compare one result beat with the oldest expectation
  task automatic check_beat(logic [103:0] data);
    gen_out_t e;
    gen_out_t got;
    got.raw    = data[31:0];
    got.ranged = data[63:32];
    got.word   = data[95:64];
    got.pos    = data[99:96];
    if (expected_outs.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result beat: raw %h ranged %h word %h pos %0d",
                 got.raw, got.ranged, got.word, got.pos);
      return;
    end
    e = expected_outs.pop_front();
    checked++;
    if (got.raw !== e.raw || got.ranged !== e.ranged || got.word !== e.word ||
        got.pos !== e.pos) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: raw %h/%h ranged %h/%h word %h/%h pos %0d/%0d (exp/got)",
                 checked, e.raw, got.raw, e.ranged, got.ranged, e.word, got.word,
                 e.pos, got.pos);
    end
  endtask

  task automatic add_req(logic [OP_W-1:0] op, logic [31:0] value,
                         logic [SLOT_W-1:0] slot, logic [31:0] lo, logic [31:0] hi,
                         bit drain);
    gen_req_t rq;
    rq.op    = op;
    rq.value = value;
    rq.slot  = slot;
    rq.lo    = lo;
    rq.hi    = hi;
    rq.drain = drain;
    pending_reqs.push_back(rq);
    total_reqs++;
  endtask

  // driver: offers queued requests with random gaps
  gen_req_t on_bus;
  gen_req_t staged;
  bit       have_staged = 0;
  int       tx_wait     = 0;
  bit       tx_quiet    = 0;

  always @(posedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (rst) begin
      nv          = 1'b0;
      have_staged = 0;
      pos_m       = '0;
      seed_pool(DEFAULT_SEED);
    end else begin
      if (s_tvalid && s_tready) begin
        expected_outs.push_back(gen_predict(on_bus));
        in_count <= in_count + 1;
        nv = 1'b0;
      end
      if (!nv) begin
        if (!have_staged && pending_reqs.size() > 0) begin
          staged      = pending_reqs.pop_front();
          have_staged = 1;
          if ($urandom_range(0, 99) == 0) tx_quiet = !tx_quiet;
          tx_wait = tx_quiet ? 0 : $urandom_range(0, 6);
        end
        if (have_staged) begin
          if (tx_wait > 0) begin
            tx_wait--;
          end else if (!(staged.drain && expected_outs.size() != 0)) begin
            on_bus      = staged;
            have_staged = 0;
            nv          = 1'b1;
          end
        end
      end
    end
    s_tvalid <= nv;
    if (nv) begin
      s_tuser <= on_bus.op;
      s_tdata <= {4'b0, on_bus.hi, on_bus.lo, on_bus.slot, on_bus.value};
    end
  end

  // long receiver hold-off once the run is under way
  int stall_left = 0;
  bit stall_done = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (!stall_done && in_count >= STALL_AT_BEAT) begin
        stall_left <= LONG_STALL;
        stall_done <= 1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // monitor: takes result beats with random stalls
  int rx_wait  = 0;
  bit rx_quiet = 0;

  always @(posedge clk) begin
    logic nr;
    if (rst) begin
      nr = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_beat(m_tdata);
        if ($urandom_range(0, 99) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 6);
      end else if (m_tvalid && rx_wait > 0) begin
        rx_wait--;
      end
      nr = (rx_wait == 0) && (stall_left == 0);
    end
    m_tready <= nr;
  end

  // watchdog
  int cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_cnt, expected_outs.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // reset
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // stimulus and end of run
  initial begin
    logic [OP_W-1:0] op;
    logic [31:0]     lo, hi;
    int              pick;

    // directed: boot seeding, range corners, every operation, spare codes
    add_req(OP_READ,   $urandom, 4'd0,  $urandom, $urandom, 1'b0);
    add_req(OP_READ,   $urandom, 4'd15, $urandom, $urandom, 1'b0);
    add_req(OP_NEXT,   32'h0, 4'd0,  INT_MIN_W, INT_MAX_W, 1'b0);
    add_req(OP_NEXT,   32'hffff_ffff, 4'd15, 32'd5, 32'd4, 1'b0);
    add_req(OP_NEXT,   $urandom, SLOT_W'($urandom), INT_MAX_W, INT_MIN_W, 1'b0);
    add_req(OP_NEXT,   $urandom, SLOT_W'($urandom), INT_MIN_W, INT_MIN_W, 1'b0);
    add_req(OP_NEXT,   $urandom, SLOT_W'($urandom), INT_MAX_W, INT_MAX_W, 1'b0);
    add_req(OP_NEXT,   $urandom, SLOT_W'($urandom), 32'hffff_ffff, 32'h0, 1'b0);
    add_req(OP_WRITE,  32'h0, 4'd0, $urandom, $urandom, 1'b0);
    add_req(OP_WRITE,  32'hffff_ffff, 4'd15, $urandom, $urandom, 1'b0);
    add_req(OP_SETPOS, $urandom, 4'd15, $urandom, $urandom, 1'b0);
    add_req(OP_NEXT,   $urandom, SLOT_W'($urandom), 32'h0, 32'd9, 1'b0);
    add_req(OP_SETPOS, $urandom, 4'd0, $urandom, $urandom, 1'b0);
    add_req(OP_NEXT,   $urandom, SLOT_W'($urandom), 32'h0, 32'd9, 1'b0);
    add_req(OP_RESEED, 32'h0, SLOT_W'($urandom), $urandom, $urandom, 1'b0);
    add_req(OP_READ,   $urandom, 4'd15, $urandom, $urandom, 1'b0);
    add_req(OP_RESEED, 32'hffff_ffff, SLOT_W'($urandom), $urandom, $urandom, 1'b0);
    add_req(OP_READ,   $urandom, 4'd7, $urandom, $urandom, 1'b0);
    for (int s = OP_SPARE_FIRST; s <= OP_SPARE_LAST; s++)
      add_req(OP_W'(s), $urandom, SLOT_W'($urandom), $urandom, $urandom, 1'b0);
    add_req(OP_RESEED, DEFAULT_SEED, SLOT_W'($urandom), $urandom, $urandom, 1'b1);
    add_req(OP_NEXT,   $urandom, SLOT_W'($urandom), $urandom, $urandom, 1'b0);

    // random mix, mostly next-number steps over assorted ranges
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 64)      op = OP_NEXT;
      else if (pick < 76) op = OP_READ;
      else if (pick < 85) op = OP_WRITE;
      else if (pick < 92) op = OP_SETPOS;
      else if (pick < 96) op = OP_RESEED;
      else                op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      case ($urandom_range(0, 5))
        0: begin lo = $urandom; hi = $urandom; end
        1: begin lo = $urandom; hi = lo + $urandom_range(0, 1000); end
        2: begin lo = INT_MIN_W; hi = INT_MAX_W; end
        3: begin lo = $urandom; hi = lo; end
        4: begin lo = -$urandom_range(0, 100); hi = $urandom_range(0, 100); end
        default: begin lo = $urandom; hi = lo - $urandom_range(1, 1000); end
      endcase
      add_req(op, $urandom, SLOT_W'($urandom), lo, hi, n == RANDOM_ITEMS / 2);
    end

    @(negedge rst);
    do @(posedge clk);
    while (in_count != total_reqs || expected_outs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_outs.size() != 0) mismatches++;
    $display("run covered %0d beats: %0d next, %0d reseed, %0d write, %0d setpos, %0d read",
             in_count, op_seen[OP_NEXT], op_seen[OP_RESEED], op_seen[OP_WRITE],
             op_seen[OP_SETPOS], op_seen[OP_READ]);
    $display("%0d spare codes, %0d empty ranges, %0d results checked, %0d failures",
             op_seen[5] + op_seen[6] + op_seen[7], empty_ranges, checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/well512_pkg.sv
rtl/core/well512_dp.sv
rtl/core/well512_ctrl.sv
rtl/core/well512_random_generator.sv
verif/tb.sv
